// ----- rtl/core/ffha_pkg.sv -----
`default_nettype none

package ffha_pkg;

  localparam int MEM_WORDS_DEF = 16384;
  localparam int HEAP_BASE_DEF = 2048;

  localparam int FIELD_W = 14;
  localparam int WORD_W = 16;

  localparam logic [WORD_W-1:0] NULL_LINK = 16'hFFFF;
  localparam int SPLIT_MIN = 2;

  localparam logic MODE_FREE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] request_length;
    logic [FIELD_W-1:0] free_address;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] granted_address;
    logic               failed;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator.sv -----
// First-fit free-list heap allocator over a MEM_WORDS x 16 single memory. After reset the
// block runs a clearing pass over every address that loads the initial heap image, with
// in_stall held high. A free goes from acceptance to a result in the output register through
// two writes, then the handover. An allocate makes two memory reads per free segment
// visited on the walk (one for the link word, one for the length word). When the list
// ends it adds the null link read and the handover. When a segment fits it adds an unlink
// (next link read, one write, handover) or a split (next link read, four writes, handover).
// A walk that is cut off after MEM_WORDS links fails. The memory has one read and one
// write port with registered read. A finished result waits in the output register while
// the next word is accepted; a request is taken only after the previous result has entered
// that register, at the earliest in the cycle after.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int MEM_WORDS = ffha_pkg::MEM_WORDS_DEF,
  parameter int HEAP_BASE = ffha_pkg::HEAP_BASE_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ffha_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ffha_pkg::out_t      out_data
);

  localparam int AW = $clog2(MEM_WORDS);

  logic                          res_valid, res_take;
  ffha_pkg::out_t                res;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [ffha_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;

  ffha_seq #(
    .MEM_WORDS(MEM_WORDS),
    .HEAP_BASE(HEAP_BASE)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  ffha_ram #(
    .WIDTH(ffha_pkg::WORD_W),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ffha_ram.sv -----
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ffha_seq.sv -----
`default_nettype none

module ffha_seq #(
  parameter int MEM_WORDS = ffha_pkg::MEM_WORDS_DEF,
  parameter int HEAP_BASE = ffha_pkg::HEAP_BASE_DEF,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ffha_pkg::in_t                 in_data,
  output logic                               res_valid,
  input  wire logic                          res_take,
  output ffha_pkg::out_t                     res,
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_waddr,
  output logic [ffha_pkg::WORD_W-1:0]        ram_wdata,
  output logic [AW-1:0]                      ram_raddr,
  input  wire logic [ffha_pkg::WORD_W-1:0]   ram_rdata
);

  localparam int WW = ffha_pkg::WORD_W;
  localparam int FW = ffha_pkg::FIELD_W;
  localparam int HB_I = HEAP_BASE % MEM_WORDS;
  localparam logic [AW-1:0] HB = AW'(HB_I);
  localparam logic [AW-1:0] HB1 = AW'((HB_I + 1) % MEM_WORDS);
  localparam logic [AW-1:0] HB2 = AW'((HB_I + 2) % MEM_WORDS);
  localparam logic [WW-1:0] LEN_INIT = WW'(MEM_WORDS - HEAP_BASE - 2);
  localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);
  localparam logic [20:0] MW = 21'(MEM_WORDS);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_A_LINK   = 4'd2;
  localparam logic [3:0] S_A_LEN    = 4'd3;
  localparam logic [3:0] S_A_NEXT   = 4'd4;
  localparam logic [3:0] S_W_LEN    = 4'd5;
  localparam logic [3:0] S_W_MID    = 4'd6;
  localparam logic [3:0] S_W_REM    = 4'd7;
  localparam logic [3:0] S_W_PREV   = 4'd8;
  localparam logic [3:0] S_W_UNLINK = 4'd9;
  localparam logic [3:0] S_F_HEAD   = 4'd10;
  localparam logic [3:0] S_F_PUSH   = 4'd11;
  localparam logic [3:0] S_RESP     = 4'd12;

  // Reduces a value below 32 * MEM_WORDS to a memory address.
  function automatic logic [AW-1:0] wrap(input logic [20:0] x);
    logic [20:0] v;
    v = x;
    for (int k = 4; k >= 0; k--) begin
      if (v >= (MW << k)) begin
        v = v - (MW << k);
      end
    end
    return v[AW-1:0];
  endfunction

  function automatic logic [WW-1:0] init_word(input logic [AW-1:0] a);
    logic [WW-1:0] w;
    w = '0;
    if (a == HB) begin
      w = WW'(HB2);
    end else if (a == HB1) begin
      w = LEN_INIT;
    end else if (a == HB2) begin
      w = ffha_pkg::NULL_LINK;
    end
    return w;
  endfunction

  logic [3:0]    state, state_next;
  logic [AW-1:0] clr, clr_next;
  logic [AW-1:0] cur, prev, len_addr, mid_addr, rem_addr, seg, steps;
  logic [FW-1:0] req;
  logic [WW-1:0] old_len, nxt_link;
  logic          split;

  logic [AW-1:0] link_addr, link_m1, mid_c, rem_c, seg_c;
  logic [WW-1:0] req_w;
  logic          len_ok, split_c, is_null, at_last;

  assign req_w = WW'(req);
  assign link_addr = wrap(21'(ram_rdata));
  assign link_m1 = (link_addr == '0) ? LAST : link_addr - 1'b1;
  assign len_ok = ram_rdata >= req_w;
  assign split_c = (ram_rdata - req_w) >= WW'(ffha_pkg::SPLIT_MIN);
  assign mid_c = wrap(21'(cur) + 21'(req));
  assign rem_c = wrap(21'(cur) + 21'(req) + 21'd1);
  assign seg_c = wrap(21'(in_data.free_address));
  assign is_null = ram_rdata == ffha_pkg::NULL_LINK;
  assign at_last = steps == LAST;

  always_comb begin
    state_next = state;
    clr_next = clr;
    in_stall = 1'b1;
    res_valid = 1'b0;
    ram_we = 1'b0;
    ram_waddr = prev;
    ram_wdata = nxt_link;
    ram_raddr = cur;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr;
        ram_wdata = init_word(clr);
        clr_next = clr + 1'b1;
        if (clr == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        ram_raddr = HB;
        if (in_valid) begin
          state_next = (in_data.mode == ffha_pkg::MODE_FREE) ? S_F_HEAD : S_A_LINK;
        end
      end
      S_A_LINK: begin
        ram_raddr = link_m1;
        state_next = is_null ? S_RESP : S_A_LEN;
      end
      S_A_LEN: begin
        ram_raddr = cur;
        if (len_ok) begin
          state_next = S_A_NEXT;
        end else if (at_last) begin
          state_next = S_RESP;
        end else begin
          state_next = S_A_LINK;
        end
      end
      S_A_NEXT: begin
        state_next = split ? S_W_LEN : S_W_UNLINK;
      end
      S_W_LEN: begin
        ram_we = 1'b1;
        ram_waddr = len_addr;
        ram_wdata = req_w;
        state_next = S_W_MID;
      end
      S_W_MID: begin
        ram_we = 1'b1;
        ram_waddr = mid_addr;
        ram_wdata = old_len - req_w - 1'b1;
        state_next = S_W_REM;
      end
      S_W_REM: begin
        ram_we = 1'b1;
        ram_waddr = rem_addr;
        ram_wdata = nxt_link;
        state_next = S_W_PREV;
      end
      S_W_PREV: begin
        ram_we = 1'b1;
        ram_waddr = prev;
        ram_wdata = WW'(rem_addr);
        state_next = S_RESP;
      end
      S_W_UNLINK: begin
        ram_we = 1'b1;
        ram_waddr = prev;
        ram_wdata = nxt_link;
        state_next = S_RESP;
      end
      S_F_HEAD: begin
        ram_we = 1'b1;
        ram_waddr = seg;
        ram_wdata = ram_rdata;
        state_next = S_F_PUSH;
      end
      S_F_PUSH: begin
        ram_we = 1'b1;
        ram_waddr = HB;
        ram_wdata = WW'(seg);
        state_next = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
    end else begin
      state <= state_next;
      clr <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req <= in_data.request_length;
        cur <= HB;
        prev <= HB;
        steps <= '0;
        seg <= seg_c;
        res <= '0;
      end
      S_A_LINK: begin
        if (is_null) begin
          res.failed <= 1'b1;
        end else begin
          prev <= cur;
          cur <= link_addr;
          len_addr <= link_m1;
        end
      end
      S_A_LEN: begin
        if (len_ok) begin
          old_len <= ram_rdata;
          split <= split_c;
          mid_addr <= mid_c;
          rem_addr <= rem_c;
        end else if (at_last) begin
          res.failed <= 1'b1;
        end else begin
          steps <= steps + 1'b1;
        end
      end
      S_A_NEXT: begin
        nxt_link <= ram_rdata;
      end
      S_W_PREV, S_W_UNLINK: begin
        res.granted_address <= FW'(cur);
        res.failed <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ffha_chk.sv -----
`default_nettype none

module ffha_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire ffha_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire ffha_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output word valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output word changed or dropped.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.failed |-> out_data.granted_address == '0)
    else $error("Failed request carries a nonzero address.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("A second word was taken before the first one finished.");

endmodule

bind first_fit_heap_allocator ffha_chk u_chk (.*);

`default_nettype wire

// ----- tb/first_fit_heap_checker.sv -----
`timescale 1ns / 1ps

module first_fit_heap_checker #(
  parameter int MEM_WORDS = ffha_pkg::MEM_WORDS_DEF,
  parameter int HEAP_BASE = ffha_pkg::HEAP_BASE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  ffha_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  ffha_pkg::out_t out_data,
  output int             mismatch_count,
  output int             replies_pending
);

  localparam int WW = ffha_pkg::WORD_W;
  localparam int FW = ffha_pkg::FIELD_W;

  logic [WW-1:0] heap_image [MEM_WORDS];
  ffha_pkg::out_t replies_due [$];
  int mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic void load_heap_image();
    int hb;
    hb = HEAP_BASE % MEM_WORDS;
    foreach (heap_image[i]) heap_image[i] = '0;
    heap_image[hb] = WW'((hb + 2) % MEM_WORDS);
    heap_image[(hb + 1) % MEM_WORDS] = WW'(MEM_WORDS - HEAP_BASE - 2);
    heap_image[(hb + 2) % MEM_WORDS] = ffha_pkg::NULL_LINK;
  endfunction

  // Updates the heap image for one request word and returns the reply word it causes.
  function automatic ffha_pkg::out_t apply_heap_request(ffha_pkg::in_t w);
    int hb;
    int prev;
    int cur;
    int len_at;
    int rem;
    int steps;
    int req;
    logic [WW-1:0] link_word;
    logic [WW-1:0] old_len;
    logic [WW-1:0] next_link;
    bit found;
    ffha_pkg::out_t r;
    hb = HEAP_BASE % MEM_WORDS;
    r = '0;
    if (w.mode == ffha_pkg::MODE_FREE) begin
      cur = int'(w.free_address) % MEM_WORDS;
      heap_image[cur] = heap_image[hb];
      heap_image[hb] = WW'(cur);
      return r;
    end
    req = int'(w.request_length);
    prev = hb;
    cur = hb;
    found = 1'b0;
    for (steps = 0; steps < MEM_WORDS; steps++) begin
      link_word = heap_image[cur];
      if (link_word == ffha_pkg::NULL_LINK) break;
      prev = cur;
      cur = int'(link_word) % MEM_WORDS;
      if (int'(heap_image[(cur + MEM_WORDS - 1) % MEM_WORDS]) >= req) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      r.failed = 1'b1;
      return r;
    end
    len_at = (cur + MEM_WORDS - 1) % MEM_WORDS;
    old_len = heap_image[len_at];
    next_link = heap_image[cur];
    if (int'(old_len) - req >= ffha_pkg::SPLIT_MIN) begin
      rem = (cur + req + 1) % MEM_WORDS;
      heap_image[len_at] = WW'(req);
      heap_image[(cur + req) % MEM_WORDS] = WW'(int'(old_len) - req - 1);
      heap_image[rem] = next_link;
      heap_image[prev] = WW'(rem);
    end else begin
      heap_image[prev] = next_link;
    end
    r.granted_address = FW'(cur);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    ffha_pkg::out_t want;
    if (rst) begin
      load_heap_image();
      replies_due.delete();
    end else begin
      if (in_valid && !in_stall) replies_due.push_back(apply_heap_request(in_data));
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("word with granted_address %0d failed %0d not expected",
                                    out_data.granted_address, out_data.failed));
        end else begin
          want = replies_due.pop_front();
          if (out_data.granted_address !== want.granted_address)
            report_mismatch($sformatf("granted_address %0d, expected %0d",
                                      out_data.granted_address, want.granted_address));
          if (out_data.failed !== want.failed)
            report_mismatch($sformatf("failed %0d, expected %0d",
                                      out_data.failed, want.failed));
        end
      end
    end
    replies_pending <= replies_due.size();
  end

endmodule

// ----- tb/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

  localparam int FW = ffha_pkg::FIELD_W;
  localparam logic MODE_ALLOC = ~ffha_pkg::MODE_FREE;
  localparam int HEAP_BASE = ffha_pkg::HEAP_BASE_DEF;
  localparam int LEN_MAX = ffha_pkg::MEM_WORDS_DEF - ffha_pkg::HEAP_BASE_DEF - 2;
  localparam int RANDOM_WORDS = 950;
  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ffha_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffha_pkg::out_t out_data;

  int mismatch_count;
  int replies_pending;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_style = 0;
  logic [FW-1:0] granted_pool [$];

  first_fit_heap_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  first_fit_heap_checker heap_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(3, 0);
      stall_left <= $urandom_range(400, 50);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99, 0) < 30);
      2: out_stall <= ($urandom_range(99, 0) < 85);
      default: out_stall <= stall_left[2];
    endcase
  end

  // Granted segments are collected on the falling edge ahead of the edge that takes them.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall && !out_data.failed && out_data.granted_address != '0)
      granted_pool.push_back(out_data.granted_address);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic ffha_pkg::in_t alloc_word(input int unsigned len);
    ffha_pkg::in_t w;
    w.mode = MODE_ALLOC;
    w.request_length = FW'(len);
    w.free_address = FW'($urandom);
    return w;
  endfunction

  function automatic ffha_pkg::in_t free_word(input logic [FW-1:0] seg);
    ffha_pkg::in_t w;
    w.mode = ffha_pkg::MODE_FREE;
    w.request_length = FW'($urandom_range(LEN_MAX, 0));
    w.free_address = seg;
    return w;
  endfunction

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 70) return $urandom_range(15, 0);
    if (roll < 93) return $urandom_range(255, 16);
    if (roll < 98) return $urandom_range(2047, 256);
    return $urandom_range(LEN_MAX, 2048);
  endfunction

  task automatic send_word(input ffha_pkg::in_t w);
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(9, 0) == 0) ? 120 : $urandom_range(24, 1);
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
  endtask

  initial begin
    int slot;
    logic [FW-1:0] seg;
    do @(posedge clk); while (rst);

    // Fresh heap: a zero-length split, then small splits off the single segment.
    send_word(alloc_word(0));
    send_word(alloc_word(5));
    send_word(alloc_word(4));
    send_word(alloc_word(3));
    drain_replies();
    repeat (4) send_word(free_word(granted_pool.pop_front()));
    // Exact fit, one word spare, two words spare, then a too-short remainder is skipped.
    send_word(alloc_word(3));
    send_word(alloc_word(3));
    send_word(alloc_word(3));
    send_word(alloc_word(2));
    send_word(alloc_word(LEN_MAX));
    send_word(alloc_word(1));
    send_word(alloc_word(0));
    send_word(alloc_word(LEN_MAX - 1));
    send_word(free_word(FW'(HEAP_BASE + 2)));
    send_word(alloc_word(LEN_MAX));
    drain_replies();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (granted_pool.size() != 0 && $urandom_range(99, 0) < 45) begin
        slot = $urandom_range(granted_pool.size() - 1, 0);
        seg = granted_pool[slot];
        granted_pool.delete(slot);
        send_word(free_word(seg));
      end else begin
        send_word(alloc_word(pick_length()));
      end
    end
    drain_replies();

    // Invalid frees that corrupt the list: address wrap at both ends of memory,
    // random addresses, a double free that makes a cycle, and the list head itself.
    seg = (granted_pool.size() != 0) ? granted_pool[$] : FW'(HEAP_BASE + 2);
    send_word(free_word('0));
    send_word(alloc_word(0));
    send_word(free_word('1));
    send_word(alloc_word($urandom_range(40, 0)));
    repeat (4) send_word(free_word(FW'($urandom)));
    send_word(alloc_word(pick_length()));
    send_word(alloc_word($urandom_range(15, 0)));
    send_word(free_word(seg));
    send_word(free_word(seg));
    send_word(alloc_word(LEN_MAX));
    send_word(alloc_word($urandom_range(7, 0)));
    send_word(free_word(FW'(HEAP_BASE)));
    send_word(alloc_word(LEN_MAX));
    send_word(alloc_word(0));
    drain_replies();
    repeat (50) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- first_fit_heap_allocator.f -----
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_seq.sv
rtl/core/first_fit_heap_allocator.sv
rtl/core/ffha_chk.sv
tb/first_fit_heap_checker.sv
tb/first_fit_heap_allocator_tb.sv
